/* design/bpfm_pkg.sv */
package bpfm_pkg;

  localparam int PageW = 24;

  typedef enum logic [2:0] {
    OP_PIN   = 3'd0,
    OP_UNPIN = 3'd1,
    OP_DIRTY = 3'd2,
    OP_FORCE = 3'd3,
    OP_FLUSH = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_PINNED = 2'd1,
    ST_ABSENT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_FRAMES = 2'd1
  } reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_EMPTY,
    S_VICTIM,
    S_APPLY,
    S_FLUSH,
    S_FLUSH_END
  } state_t;

  typedef struct packed {
    logic [2:0]       op;
    logic [PageW-1:0] page_number;
  } in_t;

  typedef struct packed {
    logic [2:0]       frame_index;
    logic             hit;
    logic             read_request;
    logic             writeback_valid;
    logic [PageW-1:0] writeback_page;
    logic [1:0]       status;
    logic [31:0]      read_total;
    logic [31:0]      write_total;
    logic             last;
  } out_t;

endpackage

/* design/buffer_pool_frame_manager.sv */
// Frame table of a page buffer pool.
// Requests enter on start/in_data and are taken when busy is low. Each
// request (pin, unpin, mark dirty, force, flush) is worked on by a small
// sequencer that visits one frame per cycle through a single compare unit,
// but not while it brings the FIFO pointer back below frames in use.
// Unpin, dirty, force and a pin hit scan the frames in use for the page;
// a pin miss adds a scan for an empty frame and a victim scan, plus a
// rewind step for each wrap of the FIFO pointer after frames in use was
// lowered; a flush scans the frames in use.
// Results appear on out_data for one cycle with out_valid high; a flush
// gives one result per written-back frame or one if none; out_data.last marks the end.
// An unknown op is dropped without a result. The receiver cannot stall.
// One request at a time: busy stays high until the cycle that shows the
// last result, in which the next request may already be taken.
// Reset empties all frames, clears pins, dirty flags, counters and the
// FIFO pointer and sets LRU ranks to frame order. Registers (APB): 0 at
// byte 0 is replacement mode (0 FIFO, 1 LRU), 1 at byte 4 is frames in
// use (1..FRAMES). Write them only while busy is low.
module buffer_pool_frame_manager #(
  parameter int FRAMES = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bpfm_pkg::in_t       in_data,
  output logic                out_valid,
  output bpfm_pkg::out_t      out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import bpfm_pkg::*;

  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);

  state_t state_r, state_nxt;
  logic mode_r;
  logic [3:0] fiu_r;
  logic [FRAMES-1:0] valid_r, dirty_r;
  logic [PageW-1:0] page_r [FRAMES];
  logic [7:0] pin_r [FRAMES];
  logic [FW-1:0] rank_r [FRAMES];
  logic [FW-1:0] fptr_r;
  logic [31:0] rd_cnt_r, wr_cnt_r;
  op_t op_r;
  logic [PageW-1:0] req_page_r;
  logic [FW-1:0] idx_r, cand_r, fifo_i_r;
  logic [CW-1:0] cnt_r;
  logic found_r, hit_r, any_r;
  logic [FW-1:0] best_r;
  out_t hold_r;

  logic [CW-1:0] n;
  always_comb begin
    if (fiu_r == 4'd0) n = CW'(1);
    else if (32'(fiu_r) > FRAMES) n = CW'(FRAMES);
    else n = CW'(fiu_r);
  end

  wire wr_en = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  always_comb begin
    cfg_prdata = '0;
    case (cfg_paddr[2])
      REG_MODE[0]: cfg_prdata[0] = mode_r;
      default:     cfg_prdata[3:0] = fiu_r;
    endcase
  end

  // step around the pool modulo frames in use
  logic [FW-1:0] fifo_step;
  always_comb begin
    if (CW'(fifo_i_r) + CW'(1) >= n) fifo_step = '0;
    else fifo_step = fifo_i_r + FW'(1);
  end

  logic last_idx;
  assign last_idx = (cnt_r + CW'(1) >= n);
  logic match;
  assign match = valid_r[idx_r] && (page_r[idx_r] == req_page_r);
  logic [FW-1:0] fidx;
  assign fidx = mode_r ? idx_r : fifo_i_r;
  logic unpinned;
  assign unpinned = (pin_r[fidx] == 8'd0);
  logic flush_wb;
  assign flush_wb = valid_r[idx_r] && dirty_r[idx_r] && (pin_r[idx_r] == 8'd0);
  // FIFO pointer left beyond frames in use: subtract one pass per cycle
  logic wrap;
  assign wrap = !mode_r && (CW'(fifo_i_r) >= n);

  assign busy = (state_r != S_IDLE);
  wire accept = start && !busy;

  function automatic logic [31:0] sat(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  out_t res;
  logic res_v;
  out_t flush_res;
  always_comb begin
    state_nxt = state_r;
    res = '0;
    res_v = 1'b0;
    flush_res = '0;
    flush_res.frame_index = 3'(idx_r);
    flush_res.writeback_valid = 1'b1;
    flush_res.writeback_page = page_r[idx_r];
    flush_res.read_total = rd_cnt_r;
    flush_res.write_total = sat(wr_cnt_r);
    case (state_r)
      S_IDLE: if (accept) begin
        case (in_data.op)
          OP_PIN, OP_UNPIN, OP_DIRTY, OP_FORCE: state_nxt = S_FIND;
          OP_FLUSH: state_nxt = S_FLUSH;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_FIND: begin
        if (match) state_nxt = S_APPLY;
        else if (last_idx) state_nxt = (op_r == OP_PIN) ? S_EMPTY : S_APPLY;
      end
      S_EMPTY: begin
        if (!valid_r[idx_r]) state_nxt = S_APPLY;
        else if (last_idx) state_nxt = S_VICTIM;
      end
      S_VICTIM: begin
        if (mode_r) begin
          if (last_idx) state_nxt = S_APPLY;
        end else if (!wrap && (unpinned || last_idx)) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        state_nxt = S_IDLE;
        res_v = 1'b1;
        res.last = 1'b1;
        res.read_total = rd_cnt_r;
        res.write_total = wr_cnt_r;
        if (op_r == OP_PIN) begin
          if (hit_r) begin
            res.frame_index = 3'(cand_r);
            res.hit = 1'b1;
          end else if (!found_r) begin
            res.status = ST_PINNED;
          end else begin
            res.frame_index = 3'(cand_r);
            res.read_request = 1'b1;
            res.read_total = sat(rd_cnt_r);
            if (valid_r[cand_r] && dirty_r[cand_r]) begin
              res.writeback_valid = 1'b1;
              res.writeback_page = page_r[cand_r];
              res.write_total = sat(wr_cnt_r);
            end
          end
        end else if (!hit_r) begin
          res.status = ST_ABSENT;
        end else begin
          res.frame_index = 3'(cand_r);
          if (op_r == OP_FORCE) begin
            res.writeback_valid = 1'b1;
            res.writeback_page = page_r[cand_r];
            res.write_total = sat(wr_cnt_r);
          end
        end
      end
      S_FLUSH: begin
        if (last_idx) state_nxt = S_FLUSH_END;
        // release the held write back once another one follows it
        if (flush_wb && any_r) begin
          res_v = 1'b1;
          res = hold_r;
        end
      end
      S_FLUSH_END: begin
        state_nxt = S_IDLE;
        res_v = 1'b1;
        if (any_r) begin
          res = hold_r;
        end else begin
          res.read_total = rd_cnt_r;
          res.write_total = wr_cnt_r;
        end
        res.last = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid <= 1'b0;
      out_data <= '0;
      mode_r <= 1'b0;
      fiu_r <= 4'd8;
      valid_r <= '0;
      dirty_r <= '0;
      fptr_r <= '0;
      rd_cnt_r <= '0;
      wr_cnt_r <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        pin_r[i] <= '0;
        rank_r[i] <= FW'(i);
      end
    end else begin
      state_r <= state_nxt;
      out_valid <= res_v;
      out_data <= res;
      if (wr_en && !busy) begin
        if (cfg_paddr[2] == REG_MODE[0]) mode_r <= cfg_pwdata[0];
        else fiu_r <= cfg_pwdata[3:0];
      end
      case (state_r)
        S_IDLE: if (accept) begin
          op_r <= op_t'(in_data.op);
          req_page_r <= in_data.page_number;
          idx_r <= '0;
          cnt_r <= '0;
          found_r <= 1'b0;
          hit_r <= 1'b0;
          any_r <= 1'b0;
        end
        S_FIND: begin
          if (match) begin
            cand_r <= idx_r;
            hit_r <= 1'b1;
          end else if (!last_idx) begin
            idx_r <= idx_r + FW'(1);
            cnt_r <= cnt_r + CW'(1);
          end else begin
            idx_r <= '0;
            cnt_r <= '0;
          end
        end
        S_EMPTY: begin
          if (!valid_r[idx_r]) begin
            cand_r <= idx_r;
            found_r <= 1'b1;
          end else if (!last_idx) begin
            idx_r <= idx_r + FW'(1);
            cnt_r <= cnt_r + CW'(1);
          end else begin
            idx_r <= '0;
            cnt_r <= '0;
            fifo_i_r <= fptr_r;
          end
        end
        S_VICTIM: begin
          // LRU: keep oldest unpinned; FIFO: first unpinned from pointer
          if (mode_r) begin
            if (unpinned && (!found_r || rank_r[idx_r] > best_r)) begin
              cand_r <= idx_r;
              best_r <= rank_r[idx_r];
              found_r <= 1'b1;
            end
            idx_r <= idx_r + FW'(1);
            cnt_r <= cnt_r + CW'(1);
          end else if (wrap) begin
            fifo_i_r <= fifo_i_r - FW'(n);
          end else begin
            if (unpinned) begin
              cand_r <= fifo_i_r;
              found_r <= 1'b1;
              fptr_r <= fifo_step;
            end
            fifo_i_r <= fifo_step;
            cnt_r <= cnt_r + CW'(1);
          end
        end
        S_APPLY: begin
          if (op_r == OP_PIN) begin
            if (hit_r) begin
              if (pin_r[cand_r] != '1) pin_r[cand_r] <= pin_r[cand_r] + 8'd1;
              for (int i = 0; i < FRAMES; i++)
                if (rank_r[i] < rank_r[cand_r]) rank_r[i] <= rank_r[i] + FW'(1);
              rank_r[cand_r] <= '0;
            end else if (found_r) begin
              rd_cnt_r <= sat(rd_cnt_r);
              if (valid_r[cand_r] && dirty_r[cand_r]) wr_cnt_r <= sat(wr_cnt_r);
              valid_r[cand_r] <= 1'b1;
              dirty_r[cand_r] <= 1'b0;
              page_r[cand_r] <= req_page_r;
              pin_r[cand_r] <= 8'd1;
              for (int i = 0; i < FRAMES; i++)
                if (rank_r[i] < rank_r[cand_r]) rank_r[i] <= rank_r[i] + FW'(1);
              rank_r[cand_r] <= '0;
            end
          end else if (hit_r) begin
            case (op_r)
              OP_UNPIN: if (pin_r[cand_r] != 8'd0) pin_r[cand_r] <= pin_r[cand_r] - 8'd1;
              OP_DIRTY: dirty_r[cand_r] <= 1'b1;
              default: begin
                dirty_r[cand_r] <= 1'b0;
                wr_cnt_r <= sat(wr_cnt_r);
              end
            endcase
          end
        end
        S_FLUSH: begin
          // hold each write back until it is known whether it is the final one
          if (flush_wb) begin
            dirty_r[idx_r] <= 1'b0;
            wr_cnt_r <= sat(wr_cnt_r);
            hold_r <= flush_res;
            any_r <= 1'b1;
          end
          idx_r <= idx_r + FW'(1);
          cnt_r <= cnt_r + CW'(1);
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) |=> out_valid && out_data.last) else $error("apply without result");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.read_request |-> !out_data.hit) else $error("read on hit");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |=> !out_valid || out_data.last) else $error("stray result");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

import bpfm_pkg::*;

class frame_table_sb;
  bit        lru_mode;
  bit [3:0]  frames_cfg;
  bit        valid_q [8];
  bit [23:0] page_q [8];
  bit        dirty_q [8];
  bit [7:0]  pins [8];
  bit [2:0]  rank [8];
  bit [2:0]  fifo_ptr;
  bit [31:0] reads;
  bit [31:0] writes;
  out_t      pending [$];
  int        errors;

  function new();
    lru_mode = 0;
    frames_cfg = 4'd8;
    for (int i = 0; i < 8; i++) begin
      valid_q[i] = 0; page_q[i] = 0; dirty_q[i] = 0; pins[i] = 0; rank[i] = 3'(i);
    end
    fifo_ptr = 0; reads = 0; writes = 0; errors = 0;
  endfunction

  function int active();
    if (frames_cfg == 0) return 1;
    if (frames_cfg > 8) return 8;
    return frames_cfg;
  endfunction

  function void touch(int f);
    bit [2:0] old;
    old = rank[f];
    for (int i = 0; i < 8; i++) if (rank[i] < old) rank[i]++;
    rank[f] = 0;
  endfunction

  function int lookup(bit [23:0] pg, int n);
    for (int i = 0; i < n; i++) if (valid_q[i] && page_q[i] == pg) return i;
    return -1;
  endfunction

  function void push(int f, bit h, bit rd, bit wbv, bit [23:0] wbp, status_t st, bit lst);
    out_t r;
    r.frame_index = 3'(f); r.hit = h; r.read_request = rd; r.writeback_valid = wbv;
    r.writeback_page = wbp; r.status = st; r.read_total = reads;
    r.write_total = writes; r.last = lst;
    pending.push_back(r);
  endfunction

  function void bump_w();
    if (writes != 32'hFFFF_FFFF) writes++;
  endfunction

  function void note_request(in_t t);
    int n, m, victim, cnt;
    bit found, wbv;
    bit [23:0] wbp;
    bit [2:0] best;
    n = active();
    case (t.op)
      OP_PIN: begin
        m = lookup(t.page_number, n);
        if (m >= 0) begin
          if (pins[m] != 8'hFF) pins[m]++;
          touch(m);
          push(m, 1, 0, 0, 0, ST_OK, 1);
          return;
        end
        found = 0; victim = 0; wbv = 0; wbp = 0;
        for (int i = 0; i < n && !found; i++)
          if (!valid_q[i]) begin victim = i; found = 1; end
        if (!found) begin
          if (lru_mode) begin
            best = 0;
            for (int i = 0; i < n; i++)
              if (pins[i] == 0 && (!found || rank[i] > best)) begin
                best = rank[i]; victim = i; found = 1;
              end
          end else begin
            for (int i = 0; i < n && !found; i++) begin
              int f;
              f = (fifo_ptr % n + i) % n;
              if (pins[f] == 0) begin victim = f; found = 1; end
            end
            if (found) fifo_ptr = (victim + 1) % n;
          end
          if (!found) begin
            push(0, 0, 0, 0, 0, ST_PINNED, 1);
            return;
          end
          if (dirty_q[victim]) begin
            wbv = 1; wbp = page_q[victim]; bump_w();
          end
        end
        if (reads != 32'hFFFF_FFFF) reads++;
        valid_q[victim] = 1; page_q[victim] = t.page_number;
        dirty_q[victim] = 0; pins[victim] = 1;
        touch(victim);
        push(victim, 0, 1, wbv, wbp, ST_OK, 1);
      end
      OP_UNPIN, OP_DIRTY, OP_FORCE: begin
        m = lookup(t.page_number, n);
        if (m < 0) push(0, 0, 0, 0, 0, ST_ABSENT, 1);
        else if (t.op == OP_UNPIN) begin
          if (pins[m] > 0) pins[m]--;
          push(m, 0, 0, 0, 0, ST_OK, 1);
        end else if (t.op == OP_DIRTY) begin
          dirty_q[m] = 1;
          push(m, 0, 0, 0, 0, ST_OK, 1);
        end else begin
          dirty_q[m] = 0; bump_w();
          push(m, 0, 0, 1, page_q[m], ST_OK, 1);
        end
      end
      OP_FLUSH: begin
        cnt = 0;
        for (int i = 0; i < n; i++)
          if (valid_q[i] && dirty_q[i] && pins[i] == 0) begin
            dirty_q[i] = 0; bump_w();
            push(i, 0, 0, 1, page_q[i], ST_OK, 0);
            cnt++;
          end
        if (cnt == 0) push(0, 0, 0, 0, 0, ST_OK, 1);
        else pending[pending.size() - 1].last = 1;
      end
      default: ;
    endcase
  endfunction

  function void check_result(out_t got);
    out_t exp_r;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    if (got.frame_index !== exp_r.frame_index || got.hit !== exp_r.hit ||
        got.read_request !== exp_r.read_request ||
        got.writeback_valid !== exp_r.writeback_valid ||
        got.writeback_page !== exp_r.writeback_page || got.status !== exp_r.status ||
        got.read_total !== exp_r.read_total || got.write_total !== exp_r.write_total ||
        got.last !== exp_r.last) begin
      $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
      errors++;
    end
  endfunction
endclass

module tb_top;
  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  in_t         in_data = '0;
  logic        out_valid;
  out_t        out_data;
  logic        cfg_psel = 0;
  logic        cfg_penable = 0;
  logic        cfg_pwrite = 0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  frame_table_sb sb = new();
  int idle_cycles = 0;
  bit [23:0] pool [16];

  always #5 clk = ~clk;

  buffer_pool_frame_manager u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite), .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_data);
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // drop start only when a gap follows; back to back requests keep it high
  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if (g > 0) begin
      start <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_request(op_t op, bit [23:0] pg);
    in_t t;
    t.op = op;
    t.page_number = pg;
    start <= 1;
    in_data <= t;
    do @(posedge clk); while (busy);
    sb.note_request(t);
  endtask

  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(reg_t idx, bit [31:0] val);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= 3'(idx) << 2; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    if (idx == REG_MODE) sb.lru_mode = val[0];
    else sb.frames_cfg = val[3:0];
    @(posedge clk);
  endtask

  task automatic random_phase(int count);
    int r;
    op_t op;
    bit [23:0] pg;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45) op = OP_PIN;
      else if (r < 65) op = OP_UNPIN;
      else if (r < 78) op = OP_DIRTY;
      else if (r < 88) op = OP_FORCE;
      else if (r < 95) op = OP_FLUSH;
      else begin
        // unknown op: no result, block ignores it
        send_request(op_t'(3'($urandom_range(5, 7))), 24'($urandom));
        idle_gap();
        continue;
      end
      pg = ($urandom_range(0, 9) == 0) ? 24'($urandom) : pool[$urandom_range(0, 15)];
      send_request(op, pg);
      if (k == count / 2) drain();
      idle_gap();
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) pool[i] = 24'($urandom);
    pool[0] = 24'h000000;
    pool[1] = 24'hFFFFFF;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty pool, extremes, every op, all-pinned, flush cases
    send_request(OP_FLUSH, 0);
    send_request(OP_UNPIN, 24'h123456);
    send_request(OP_DIRTY, 24'hFFFFFF);
    send_request(OP_FORCE, 24'h000000);
    send_request(OP_UNPIN, 24'h000000);
    for (int i = 0; i < 8; i++) send_request(OP_PIN, pool[i]);
    send_request(OP_PIN, pool[1]);
    send_request(OP_PIN, pool[9]);
    send_request(OP_UNPIN, pool[2]);
    send_request(OP_UNPIN, pool[2]);
    send_request(OP_DIRTY, pool[2]);
    send_request(OP_FORCE, pool[3]);
    send_request(OP_DIRTY, pool[4]);
    send_request(OP_UNPIN, pool[4]);
    send_request(OP_FLUSH, 24'hABCDEF);
    send_request(OP_DIRTY, pool[2]);
    send_request(OP_PIN, pool[10]);
    drain();

    random_phase(50);
    drain();
    write_reg(REG_MODE, 1);
    random_phase(50);
    drain();
    write_reg(REG_FRAMES, 1);
    random_phase(30);
    drain();
    write_reg(REG_FRAMES, 3);
    write_reg(REG_MODE, 0);
    random_phase(40);
    drain();
    write_reg(REG_MODE, 1);
    write_reg(REG_FRAMES, 8);
    random_phase(50);
    drain();
    write_reg(REG_MODE, 0);
    random_phase(30);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
